### hw/rtl/tbsq_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// tbsq_pkg
// Types and constants shared by the token bucket shaper queue.
// ============================================================================
package tbsq_pkg;

    localparam int unsigned QUEUE_DEPTH_DEF = 64;
    localparam int unsigned LEVEL_W         = 10;
    localparam int unsigned ID_W            = 16;
    localparam int unsigned PAYLOAD_W       = 32;
    localparam int unsigned CNT_W           = 16;
    localparam int unsigned QCOUNT_W        = 7;

    localparam logic [LEVEL_W-1:0] DEPTH_RESET = 10'd10;

    typedef enum logic
    {
        REQ_TICK   = 1'b0,
        REQ_PACKET = 1'b1
    } req_t;

    typedef enum logic [2:0]
    {
        ST_TOKEN_ADDED   = 3'd0,
        ST_TOKEN_DROPPED = 3'd1,
        ST_QUEUED        = 3'd2,
        ST_TOO_BIG       = 3'd3,
        ST_QUEUE_FULL    = 3'd4
    } status_t;

    typedef struct packed
    {
        req_t                 req_type;
        logic [ID_W-1:0]      packet_id;
        logic [LEVEL_W-1:0]   tokens_needed;
        logic [PAYLOAD_W-1:0] service_payload;
    } in_word_t;

    typedef struct packed
    {
        status_t              event_status;
        logic [LEVEL_W-1:0]   bucket_level;
        logic                 released;
        logic [ID_W-1:0]      released_id;
        logic [PAYLOAD_W-1:0] released_payload;
        logic [CNT_W-1:0]     tokens_dropped;
        logic [CNT_W-1:0]     packets_dropped;
        logic [QCOUNT_W-1:0]  queue_count;
    } out_word_t;

    // one packet as kept in the FIFO
    typedef struct packed
    {
        logic [ID_W-1:0]      id;
        logic [LEVEL_W-1:0]   need;
        logic [PAYLOAD_W-1:0] payload;
    } entry_t;

    // classified event handed from front to back
    typedef struct packed
    {
        logic   is_tick;
        logic   too_big;
        entry_t entry;
    } cmd_t;

endpackage

### hw/rtl/tbsq_ram.sv
`timescale 1ns / 1ps
// ============================================================================
// tbsq_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ============================================================================
module tbsq_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/tbsq_front.sv
`timescale 1ns / 1ps
// ============================================================================
// tbsq_front
// Accepts event words, classifies them and holds them in a two-entry queue.
// ============================================================================
module tbsq_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [tbsq_pkg::LEVEL_W-1:0]      depth,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  tbsq_pkg::in_word_t                in_data,
    output logic                              cmd_valid,
    input  logic                              cmd_ready,
    output tbsq_pkg::cmd_t                    cmd
);
    import tbsq_pkg::*;

    cmd_t       q_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       push;
    logic       pop;
    cmd_t       cmd_new;

    assign in_ready  = (cnt_reg != 2'd2);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign push      = in_valid && in_ready;
    assign pop       = cmd_valid && cmd_ready;
    assign cmd       = q_reg[rd_ptr_reg];

    always_comb
    begin
        cmd_new.is_tick       = (in_data.req_type == REQ_TICK);
        cmd_new.too_big       = (in_data.tokens_needed > depth);
        cmd_new.entry.id      = in_data.packet_id;
        cmd_new.entry.need    = in_data.tokens_needed;
        cmd_new.entry.payload = in_data.service_payload;
    end

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        unique case ({push, pop})
            2'b10:   cnt_next = cnt_reg + 2'd1;
            2'b01:   cnt_next = cnt_reg - 2'd1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= cmd_new;
        end
    end

endmodule

### hw/rtl/tbsq_back.sv
`timescale 1ns / 1ps
// ============================================================================
// tbsq_back
// Executes one classified event per cycle unless the output stalls: bucket
// update, packet FIFO, head release, drop counters, registered result word.
// ============================================================================
module tbsq_back #(
    parameter int unsigned QUEUE_DEPTH = tbsq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [tbsq_pkg::LEVEL_W-1:0] depth,
    input  logic                         cmd_valid,
    output logic                         cmd_ready,
    input  tbsq_pkg::cmd_t               cmd,
    output logic                         out_valid,
    input  logic                         out_ready,
    output tbsq_pkg::out_word_t          out_data
);
    import tbsq_pkg::*;

    localparam int unsigned AW = $clog2(QUEUE_DEPTH);
    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned EW = $bits(entry_t);

    logic [LEVEL_W-1:0] level_reg, level_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [AW-1:0]      head_reg, head_next;
    logic [AW-1:0]      tail_reg, tail_next;
    logic [CNT_W-1:0]   tdrop_reg, tdrop_next;
    logic [CNT_W-1:0]   pdrop_reg, pdrop_next;
    logic               out_valid_reg, out_valid_next;
    out_word_t          out_data_reg, out_data_next;
    logic               byp_valid_reg, byp_valid_next;
    entry_t             byp_data_reg;

    logic               fire;
    logic               enq;
    logic               rel;
    status_t            status;
    logic [LEVEL_W-1:0] level_a, level_b;
    logic [CW-1:0]      count_a, count_b;
    logic [CNT_W-1:0]   tdrop_s, pdrop_s;
    entry_t             head_entry;
    entry_t             head_data;
    logic [EW-1:0]      ram_rdata;
    logic               ram_we;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        ptr_inc = (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    assign cmd_ready = !out_valid_reg || out_ready;
    assign fire      = cmd_valid && cmd_ready;
    assign ram_we    = fire && enq;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // newest write to the slot being read wins over the RAM's old data
    assign head_data = byp_valid_reg ? byp_data_reg : entry_t'(ram_rdata);

    // event step
    always_comb
    begin
        level_a = level_reg;
        count_a = count_reg;
        tdrop_s = tdrop_reg;
        pdrop_s = pdrop_reg;
        enq     = 1'b0;
        priority if (cmd.is_tick)
        begin
            if (level_reg >= depth)
            begin
                status  = ST_TOKEN_DROPPED;
                tdrop_s = (tdrop_reg != '1) ? tdrop_reg + CNT_W'(1) : tdrop_reg;
            end
            else
            begin
                status  = ST_TOKEN_ADDED;
                level_a = level_reg + LEVEL_W'(1);
            end
        end
        else if (cmd.too_big)
        begin
            status  = ST_TOO_BIG;
            pdrop_s = (pdrop_reg != '1) ? pdrop_reg + CNT_W'(1) : pdrop_reg;
        end
        else if (count_reg == CW'(QUEUE_DEPTH))
        begin
            status  = ST_QUEUE_FULL;
            pdrop_s = (pdrop_reg != '1) ? pdrop_reg + CNT_W'(1) : pdrop_reg;
        end
        else
        begin
            status  = ST_QUEUED;
            enq     = 1'b1;
            count_a = count_reg + CW'(1);
        end

        // an empty queue that just took a packet has it at the head
        head_entry = (count_reg == '0) ? cmd.entry : head_data;
        rel        = (count_a != '0) && (level_a >= head_entry.need);
        level_b    = rel ? level_a - head_entry.need : level_a;
        count_b    = rel ? count_a - CW'(1) : count_a;
    end

    // state update
    always_comb
    begin
        level_next     = level_reg;
        count_next     = count_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        tdrop_next     = tdrop_reg;
        pdrop_next     = pdrop_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (fire)
        begin
            level_next = level_b;
            count_next = count_b;
            head_next  = rel ? ptr_inc(head_reg) : head_reg;
            tail_next  = enq ? ptr_inc(tail_reg) : tail_reg;
            tdrop_next = tdrop_s;
            pdrop_next = pdrop_s;
            out_valid_next                 = 1'b1;
            out_data_next.event_status     = status;
            out_data_next.bucket_level     = level_b;
            out_data_next.released         = rel;
            out_data_next.released_id      = rel ? head_entry.id : '0;
            out_data_next.released_payload = rel ? head_entry.payload : '0;
            out_data_next.tokens_dropped   = tdrop_s;
            out_data_next.packets_dropped  = pdrop_s;
            out_data_next.queue_count      = QCOUNT_W'(count_b);
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        byp_valid_next = ram_we && (tail_reg == head_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg     <= '0;
            count_reg     <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            tdrop_reg     <= '0;
            pdrop_reg     <= '0;
            out_valid_reg <= 1'b0;
            byp_valid_reg <= 1'b0;
        end
        else
        begin
            level_reg     <= level_next;
            count_reg     <= count_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            tdrop_reg     <= tdrop_next;
            pdrop_reg     <= pdrop_next;
            out_valid_reg <= out_valid_next;
            byp_valid_reg <= byp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        byp_data_reg <= cmd.entry;
    end

    tbsq_ram #(
        .WIDTH (EW),
        .DEPTH (QUEUE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (tail_reg),
        .wdata (cmd.entry),
        .raddr (head_next),
        .rdata (ram_rdata)
    );

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(QUEUE_DEPTH))
        else $error("queue count above depth");

    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (head_reg == tail_reg))
        else $error("empty queue with head and tail apart");

    a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
        (head_reg < AW'(QUEUE_DEPTH - 1)) || (head_reg == AW'(QUEUE_DEPTH - 1)))
        else $error("head pointer out of range");

    a_fire_result: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> (out_valid_reg && (out_data_reg.bucket_level == $past(level_b))))
        else $error("executed event left no result word");

    a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && !cmd.is_tick && !cmd.too_big && (count_reg == CW'(QUEUE_DEPTH)))
            |=> (out_data_reg.event_status == ST_QUEUE_FULL))
        else $error("full queue accepted a packet");
`endif

endmodule

### hw/rtl/token_bucket_shaper_queue.sv
`timescale 1ns / 1ps
// ============================================================================
// token_bucket_shaper_queue
// Token bucket shaper in front of a packet FIFO, one result word per event.
// ============================================================================
// Each accepted event word (token tick or packet arrival) gives exactly one
// result word. Throughput is one event per clock unless the output stalls:
// the front classifies words into a two-entry queue, and the back executes
// one event per cycle against the bucket level, the packet FIFO RAM and the
// drop counters, releasing at most one head packet. The head slot is read
// from the RAM at the next head pointer, with a bypass for a packet written
// to the slot being read. An event passes the front queue and then the
// registered result word; in_ready falls only when the two-entry queue fills
// under output stall. Write bucket_depth only while no event is in flight.
module token_bucket_shaper_queue #(
    parameter int unsigned QUEUE_DEPTH = tbsq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic [tbsq_pkg::LEVEL_W-1:0] cfg_wr_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  tbsq_pkg::in_word_t           in_data,
    output logic                         out_valid,
    input  logic                         out_ready,
    output tbsq_pkg::out_word_t          out_data
);
    import tbsq_pkg::*;

    logic [LEVEL_W-1:0] depth_reg;
    logic [LEVEL_W-1:0] depth_next;
    logic               cmd_valid;
    logic               cmd_ready;
    cmd_t               cmd;

    assign depth_next = cfg_wr_en ? cfg_wr_data : depth_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg <= DEPTH_RESET;
        end
        else
        begin
            depth_reg <= depth_next;
        end
    end

    tbsq_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .depth     (depth_reg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    tbsq_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .depth     (depth_reg),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

### test/tb.sv
`timescale 1ns / 1ps
// ============================================================================
// tb
// Self-checking bench for the token bucket shaper queue.
// Predicts every result word from its own copy of the bucket, the packet FIFO
// and the drop counters. Stimulus is directed cases first, then random
// tick and packet bursts under three idle regimes.
// ============================================================================
import tbsq_pkg::*;

class shaper_tracker;

    logic [LEVEL_W-1:0] depth;
    logic [LEVEL_W-1:0] level;
    entry_t             slots [QUEUE_DEPTH_DEF];
    int unsigned        head;
    int unsigned        tail;
    int unsigned        waiting;
    logic [CNT_W-1:0]   token_drops;
    logic [CNT_W-1:0]   packet_drops;
    out_word_t          predicted_words [$];
    int                 mismatches;

    function new();
        depth        = DEPTH_RESET;
        level        = '0;
        head         = 0;
        tail         = 0;
        waiting      = 0;
        token_drops  = '0;
        packet_drops = '0;
        mismatches   = 0;
    endfunction

    function void set_depth(input logic [LEVEL_W-1:0] d);
        depth = d;
    endfunction

    function int pending();
        return predicted_words.size();
    endfunction

    // Work out the result word for one accepted event word.
    function void admit_event(input in_word_t w);
        out_word_t e;
        entry_t    h;
        e = '0;
        if (w.req_type == REQ_TICK) begin
            if (level >= depth) begin
                if (token_drops != '1)
                    token_drops = token_drops + CNT_W'(1);
                e.event_status = ST_TOKEN_DROPPED;
            end
            else begin
                level = level + LEVEL_W'(1);
                e.event_status = ST_TOKEN_ADDED;
            end
        end
        else if (w.tokens_needed > depth) begin
            if (packet_drops != '1)
                packet_drops = packet_drops + CNT_W'(1);
            e.event_status = ST_TOO_BIG;
        end
        else if (waiting >= QUEUE_DEPTH_DEF) begin
            if (packet_drops != '1)
                packet_drops = packet_drops + CNT_W'(1);
            e.event_status = ST_QUEUE_FULL;
        end
        else begin
            slots[tail].id      = w.packet_id;
            slots[tail].need    = w.tokens_needed;
            slots[tail].payload = w.service_payload;
            tail = (tail + 1) % QUEUE_DEPTH_DEF;
            waiting++;
            e.event_status = ST_QUEUED;
        end
        // release at most one head packet, whatever the event did
        if (waiting > 0) begin
            h = slots[head];
            if (level >= h.need) begin
                level              = level - h.need;
                e.released         = 1'b1;
                e.released_id      = h.id;
                e.released_payload = h.payload;
                head = (head + 1) % QUEUE_DEPTH_DEF;
                waiting--;
            end
        end
        e.bucket_level    = level;
        e.tokens_dropped  = token_drops;
        e.packets_dropped = packet_drops;
        e.queue_count     = waiting[QCOUNT_W-1:0];
        predicted_words.push_back(e);
    endfunction

    function void compare_field(input string name, input logic [31:0] exp,
                                input logic [31:0] act);
        if (exp !== act) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp, act);
            mismatches++;
        end
    endfunction

    function void check_event_result(input out_word_t got);
        out_word_t e;
        if (predicted_words.size() == 0) begin
            $display("%0t: unexpected result word, expected none, got %h", $time, got);
            mismatches++;
            return;
        end
        e = predicted_words.pop_front();
        compare_field("event_status", 32'(e.event_status), 32'(got.event_status));
        compare_field("bucket_level", 32'(e.bucket_level), 32'(got.bucket_level));
        compare_field("released", 32'(e.released), 32'(got.released));
        compare_field("released_id", 32'(e.released_id), 32'(got.released_id));
        compare_field("released_payload", e.released_payload, got.released_payload);
        compare_field("tokens_dropped", 32'(e.tokens_dropped), 32'(got.tokens_dropped));
        compare_field("packets_dropped", 32'(e.packets_dropped),
                      32'(got.packets_dropped));
        compare_field("queue_count", 32'(e.queue_count), 32'(got.queue_count));
    endfunction

endclass

module tb;

    localparam int STALL_LIMIT = 2000;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_wr_en;
    logic [LEVEL_W-1:0] cfg_wr_data;
    logic               in_valid;
    logic               in_ready;
    in_word_t           in_data;
    logic               out_valid;
    logic               out_ready = 1'b0;
    out_word_t          out_data;

    shaper_tracker tracker;
    int            send_idle_pct;
    int            recv_idle_pct;
    int            stall_cycles = 0;

    token_bucket_shaper_queue dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            tracker.check_event_result(out_data);
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("token_bucket_shaper_queue verification failed");
            $finish;
        end
    end

    function automatic in_word_t make_word(input req_t kind, input logic [ID_W-1:0] id,
                                           input logic [LEVEL_W-1:0] need,
                                           input logic [PAYLOAD_W-1:0] payload);
        in_word_t w;
        w.req_type        = kind;
        w.packet_id       = id;
        w.tokens_needed   = need;
        w.service_payload = payload;
        return w;
    endfunction

    function automatic in_word_t tick_word();
        return make_word(REQ_TICK, ID_W'($urandom), LEVEL_W'($urandom),
                         PAYLOAD_W'($urandom));
    endfunction

    // mostly small needs so the bucket can cover them in a short tick run
    function automatic logic [LEVEL_W-1:0] pick_need(input int unsigned d);
        if ($urandom_range(99) < 70)
            return LEVEL_W'($urandom_range(0, (d < 12) ? d : 12));
        return LEVEL_W'($urandom_range(0, d));
    endfunction

    function automatic in_word_t random_word(input int unsigned pick);
        in_word_t w;
        w = make_word(REQ_PACKET, ID_W'($urandom), LEVEL_W'($urandom_range(0, 1023)),
                      PAYLOAD_W'($urandom));
        if (pick < 45)
            w.tokens_needed = pick_need(32'(tracker.depth));
        else if (pick < 75)
            w.req_type = REQ_TICK;
        else if (pick < 90) begin
            w.req_type = $urandom_range(1) ? REQ_PACKET : REQ_TICK;
            w.tokens_needed = pick_need(32'(tracker.depth));
        end
        else
            w.req_type = $urandom_range(1) ? REQ_PACKET : REQ_TICK;
        return w;
    endfunction

    task automatic send_word(input in_word_t w);
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        do @(posedge clk); while (!in_ready);
        tracker.admit_event(w);
    endtask

    // hold off until every predicted word has come back
    task automatic drain();
        in_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_depth(input logic [LEVEL_W-1:0] d);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= d;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        tracker.set_depth(d);
    endtask

    task automatic run_random(input int unsigned count);
        int unsigned left;
        int unsigned len;
        int unsigned pick;
        left = count;
        while (left > 0) begin
            pick = $urandom_range(99);
            len = (pick < 45) ? $urandom_range(1, 80) : $urandom_range(1, 30);
            if (len > left)
                len = left;
            repeat (len) send_word(random_word(pick));
            left -= len;
        end
    endtask

    task automatic run_directed();
        send_word(tick_word());
        // zero need into an empty queue: queued and released at once
        send_word(make_word(REQ_PACKET, 16'hFFFF, 10'd0, 32'hFFFF_FFFF));
        send_word(make_word(REQ_PACKET, 16'h0000, 10'd1023, 32'h0000_0000));
        // head blocked on a bucket short of its need, a zero-need packet behind it
        send_word(make_word(REQ_PACKET, 16'h0001, 10'd10, PAYLOAD_W'($urandom)));
        send_word(make_word(REQ_PACKET, 16'h0002, 10'd0, PAYLOAD_W'($urandom)));
        repeat (9) send_word(tick_word());
        // second head leaves on a too-big drop
        send_word(make_word(REQ_PACKET, ID_W'($urandom), 10'd11, PAYLOAD_W'($urandom)));
        repeat (11) send_word(tick_word());
        // lower depth below the level: ticks drop, and still drop after a release
        write_depth(10'd3);
        send_word(tick_word());
        send_word(make_word(REQ_PACKET, ID_W'($urandom), 10'd3, PAYLOAD_W'($urandom)));
        send_word(tick_word());
        write_depth(10'd0);
        send_word(tick_word());
        send_word(make_word(REQ_PACKET, ID_W'($urandom), 10'd0, PAYLOAD_W'($urandom)));
        send_word(make_word(REQ_PACKET, ID_W'($urandom), 10'd1, PAYLOAD_W'($urandom)));
    endtask

    initial
    begin
        tracker       = new();
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_data       = '0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        send_idle_pct = 10;
        recv_idle_pct = 86;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        write_depth(10'd1023);
        run_random(130);

        send_idle_pct = 86;
        recv_idle_pct = 10;
        write_depth(10'd1);
        run_random(130);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_depth(LEVEL_W'($urandom_range(2, 40)));
        run_random(140);

        drain();
        repeat (10) @(posedge clk);
        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("token_bucket_shaper_queue verification clean");
        else
            $display("token_bucket_shaper_queue verification failed");
        $finish;
    end

endmodule
